### rtl/core/tfna_pkg.sv
// ----------------------------------------------------------------------------
// tfna_pkg
// Widths, stage records and step functions for the face normal/area pipe.
// ----------------------------------------------------------------------------
package tfna_pkg;

   localparam int COORD_BITS  = 24;
   localparam int NORMAL_BITS = 16;
   localparam int CW   = COORD_BITS;
   localparam int EW   = CW + 1;         // edge component
   localparam int PW   = 2 * EW;         // edge product
   localparam int NW   = PW + 1;         // cross component, signed
   localparam int AW   = PW;             // cross magnitude
   localparam int HW   = AW / 2;         // half of magnitude for squaring
   localparam int RW   = AW + 1;         // square root width
   localparam int SW   = 2 * RW;         // sum of squares
   localparam int REMW = RW + 3;         // sqrt remainder
   localparam int DRW  = RW + 1;         // divider remainder
   localparam int QW   = NORMAL_BITS;    // quotient bits, one per stage
   localparam int AREA_BITS = 2 * CW + 2;
   localparam int NST  = 6 + RW + QW;    // stages ahead of the output register

   typedef struct packed {
      logic          neg;
      logic [AW-1:0] mag;
   } comp_type;

   typedef struct packed {
      logic [SW-1:0]   rad;
      logic [REMW-1:0] rem;
      logic [RW-1:0]   root;
      comp_type [2:0]  c;
   } sq_type;

   typedef struct packed {
      logic [RW-1:0]           m;
      comp_type [2:0]          c;
      logic [2:0][DRW-1:0]     rem;
      logic [2:0][QW-1:0]      q;
   } dv_type;

   typedef struct packed {
      logic signed [NORMAL_BITS-1:0] nx;
      logic signed [NORMAL_BITS-1:0] ny;
      logic signed [NORMAL_BITS-1:0] nz;
      logic [AREA_BITS-1:0]          area;
      logic                          deg;
   } res_type;

   // one bit of the restoring square root
   function automatic sq_type sqrt_step(sq_type s);
      sq_type          o;
      logic [REMW-1:0] remsh;
      logic [REMW-1:0] trial;
      o     = s;
      remsh = {s.rem[REMW-3:0], s.rad[SW-1:SW-2]};
      trial = REMW'({s.root, 2'b01});
      o.rad = {s.rad[SW-3:0], 2'b00};
      if (remsh >= trial) begin
         o.rem  = remsh - trial;
         o.root = {s.root[RW-2:0], 1'b1};
      end else begin
         o.rem  = remsh;
         o.root = {s.root[RW-2:0], 1'b0};
      end
      return o;
   endfunction

   // one quotient bit for all three components
   function automatic dv_type div_step(dv_type s);
      dv_type         o;
      logic [DRW-1:0] r;
      o = s;
      for (int i = 0; i < 3; i++) begin
         r = {s.rem[i][DRW-2:0], 1'b0};
         if (r >= DRW'(s.m)) begin
            o.rem[i] = r - DRW'(s.m);
            o.q[i]   = {s.q[i][QW-2:0], 1'b1};
         end else begin
            o.rem[i] = r;
            o.q[i]   = {s.q[i][QW-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   function automatic logic signed [NORMAL_BITS-1:0] fix_comp(logic neg,
                                                              logic [QW-1:0] q,
                                                              logic deg);
      logic [QW-1:0] smax;
      smax = QW'((1 << (NORMAL_BITS - 1)) - 1);
      if (deg) return '0;
      if (neg) return NORMAL_BITS'(-q);
      return NORMAL_BITS'((q > smax) ? smax : q);
   endfunction

endpackage

### rtl/core/triangle_face_normal_area_top.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_area_top
// Unit face normal (Q1.15) and doubled area (Q26.24) of one triangle per item.
// ----------------------------------------------------------------------------
//  channel | ports              | direction | contents
//  req     | req_valid/ready    | in        | three vertices, Q12.12
//  rsp     | rsp_valid/ready    | out       | normal x/y/z, area, degenerate
//
//  One item per cycle sustained while the skid is empty. There are 6 + 51 + 16
//  stages plus the output register: edges, products, cross, partial squares,
//  squares, sum of squares, one root bit per stage, one quotient bit per stage.
//  Synchronous reset clears all valid bits; data registers are not reset.
//  Stalls: the whole pipe holds only when the one-item skid behind the output
//  register is full, so an item is still taken while a result waits.
// ----------------------------------------------------------------------------
module triangle_face_normal_area_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_ax,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_ay,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_az,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_bx,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_by_coord,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_bz,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_cx,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_cy,
   input  logic signed [tfna_pkg::COORD_BITS-1:0]  req_cz,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [tfna_pkg::NORMAL_BITS-1:0] rsp_normal_x,
   output logic signed [tfna_pkg::NORMAL_BITS-1:0] rsp_normal_y,
   output logic signed [tfna_pkg::NORMAL_BITS-1:0] rsp_normal_z,
   output logic [tfna_pkg::AREA_BITS-1:0]          rsp_area,
   output logic                                    rsp_degenerate
);
   import tfna_pkg::*;

   // pipe advance: frozen only while the skid holds an item
   logic en;
   logic [NST-1:0] vld_ff, vld_in;

   // stage 1: edge vectors e1 = b - a, e2 = c - b
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   // stage 2: the edge products, a pair per cross component
   logic signed [PW-1:0] p_ff [6];
   // stage 3: cross product as sign and magnitude
   comp_type c3_ff [3];
   // stage 4: partial squares
   logic [2*HW-1:0] hh_ff [3];
   logic [2*HW-1:0] hl_ff [3];
   logic [2*HW-1:0] ll_ff [3];
   comp_type c4_ff [3];
   // stage 5: square per component
   logic [2*AW-1:0] sq5_ff [3];
   comp_type c5_ff [3];
   // stage 6: sum of squares
   logic [SW-1:0] sum_ff;
   comp_type [2:0] c6_ff;

   sq_type sq_ff [RW];
   dv_type dv_ff [QW];

   res_type res_in;
   res_type rsp_ff, skid_ff;
   logic    rsp_v_ff, skid_v_ff;
   logic    pop, last_v;

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff[0] <= EW'(req_bx) - EW'(req_ax);
         e1_ff[1] <= EW'(req_by_coord) - EW'(req_ay);
         e1_ff[2] <= EW'(req_bz) - EW'(req_az);
         e2_ff[0] <= EW'(req_cx) - EW'(req_bx);
         e2_ff[1] <= EW'(req_cy) - EW'(req_by_coord);
         e2_ff[2] <= EW'(req_cz) - EW'(req_bz);

         p_ff[0] <= e1_ff[1] * e2_ff[2];
         p_ff[1] <= e1_ff[2] * e2_ff[1];
         p_ff[2] <= e1_ff[2] * e2_ff[0];
         p_ff[3] <= e1_ff[0] * e2_ff[2];
         p_ff[4] <= e1_ff[0] * e2_ff[1];
         p_ff[5] <= e1_ff[1] * e2_ff[0];

         for (int i = 0; i < 3; i++) begin
            logic signed [NW-1:0] n;
            n = NW'(p_ff[2*i]) - NW'(p_ff[2*i+1]);
            c3_ff[i].neg <= n[NW-1];
            c3_ff[i].mag <= n[NW-1] ? AW'(-n) : AW'(n);
         end

         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= c3_ff[i].mag[AW-1:HW] * c3_ff[i].mag[AW-1:HW];
            hl_ff[i] <= c3_ff[i].mag[AW-1:HW] * c3_ff[i].mag[HW-1:0];
            ll_ff[i] <= c3_ff[i].mag[HW-1:0] * c3_ff[i].mag[HW-1:0];
            c4_ff[i] <= c3_ff[i];
         end

         // hi^2 and lo^2 do not overlap; the cross term enters twice
         for (int i = 0; i < 3; i++) begin
            sq5_ff[i] <= {hh_ff[i], ll_ff[i]} + ((2*AW)'(hl_ff[i]) << (HW + 1));
            c5_ff[i]  <= c4_ff[i];
         end

         sum_ff <= SW'(sq5_ff[0]) + SW'(sq5_ff[1]) + SW'(sq5_ff[2]);
         for (int i = 0; i < 3; i++) c6_ff[i] <= c5_ff[i];
      end
   end

   // square root, one root bit per stage
   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      sq_type sq_src;
      if (k == 0) begin : g_first
         always_comb begin
            sq_src.rad  = sum_ff;
            sq_src.rem  = '0;
            sq_src.root = '0;
            sq_src.c    = c6_ff;
         end
      end else begin : g_next
         assign sq_src = sq_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en) sq_ff[k] <= sqrt_step(sq_src);
      end
   end

   // divider: first stage takes the integer bit (|c| == m), then one bit each
   for (genvar k = 0; k < QW; k++) begin : g_div
      if (k == 0) begin : g_first
         dv_type d0;
         always_comb begin
            d0.m = sq_ff[RW-1].root;
            d0.c = sq_ff[RW-1].c;
            for (int i = 0; i < 3; i++) begin
               if (DRW'(d0.c[i].mag) >= DRW'(d0.m)) begin
                  d0.rem[i] = DRW'(d0.c[i].mag) - DRW'(d0.m);
                  d0.q[i]   = QW'(1);
               end else begin
                  d0.rem[i] = DRW'(d0.c[i].mag);
                  d0.q[i]   = '0;
               end
            end
         end
         always_ff @(posedge clock) begin
            if (en) dv_ff[0] <= d0;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) dv_ff[k] <= div_step(dv_ff[k-1]);
         end
      end
   end

   always_comb begin
      res_in.deg  = (dv_ff[QW-1].m == '0);
      res_in.nx   = fix_comp(dv_ff[QW-1].c[0].neg, dv_ff[QW-1].q[0], res_in.deg);
      res_in.ny   = fix_comp(dv_ff[QW-1].c[1].neg, dv_ff[QW-1].q[1], res_in.deg);
      res_in.nz   = fix_comp(dv_ff[QW-1].c[2].neg, dv_ff[QW-1].q[2], res_in.deg);
      res_in.area = dv_ff[QW-1].m[AREA_BITS-1:0];
   end

   assign pop    = rsp_v_ff && rsp_ready;
   assign last_v = en && vld_ff[NST-1];

   // output register with a one-item skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            rsp_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (last_v) begin
         if (!rsp_v_ff || pop) begin
            rsp_ff   <= res_in;
            rsp_v_ff <= 1'b1;
         end else begin
            skid_ff   <= res_in;
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_v_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_v_ff;
   assign rsp_normal_x   = rsp_ff.nx;
   assign rsp_normal_y   = rsp_ff.ny;
   assign rsp_normal_z   = rsp_ff.nz;
   assign rsp_area       = rsp_ff.area;
   assign rsp_degenerate = rsp_ff.deg;

endmodule

### rtl/core/tfna_checker.sv
// ----------------------------------------------------------------------------
// tfna_checker
// Port-level checks on the face normal/area block.
// ----------------------------------------------------------------------------
module tfna_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [tfna_pkg::NORMAL_BITS-1:0] rsp_normal_x,
   input logic signed [tfna_pkg::NORMAL_BITS-1:0] rsp_normal_y,
   input logic signed [tfna_pkg::NORMAL_BITS-1:0] rsp_normal_z,
   input logic [tfna_pkg::AREA_BITS-1:0]          rsp_area,
   input logic                                    rsp_degenerate
);
   import tfna_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_area) &&
      $stable(rsp_normal_x) && $stable(rsp_degenerate))
      else $error("stalled item changed");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_area == '0 && rsp_normal_x == '0 &&
      rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate item with nonzero fields");

   a_area_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_area != '0)
      else $error("zero area without degenerate flag");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("item out of reset");

endmodule

bind triangle_face_normal_area_top tfna_checker u_tfna_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
   .rsp_normal_z(rsp_normal_z), .rsp_area(rsp_area),
   .rsp_degenerate(rsp_degenerate)
);
